[hw/rtl/smt_pkg.sv]
`default_nettype none

package smt_pkg;

    // Square root unit: radicand width and one result bit per stage
    localparam int ISQ_N = 25;
    localparam int ISQ_W = 2 * ISQ_N;

    // Divider unit: dividend and divisor widths, one quotient bit per stage
    localparam int DIV_N  = 17;
    localparam int DIV_AW = 41;
    localparam int DIV_DW = 25;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_CAMERA_X = 2'd0,
        CFG_CAMERA_Y = 2'd1,
        CFG_CAMERA_Z = 2'd2
    } t_cfg_idx;

    // Side data carried around the first square root
    typedef struct packed {
        logic signed [24:0] vx;
        logic signed [24:0] vy;
        logic signed [24:0] vz;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               zero;
    } t_sb_len;

    // Side data carried around the normalizing divide
    typedef struct packed {
        logic [2:0]         neg;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               zero;
    } t_sb_norm;

    // Side data carried around the second square root
    typedef struct packed {
        logic signed [24:0] xs;
        logic signed [24:0] ys;
        logic               center;
    } t_sb_root;

    // Side data carried around the final divide
    typedef struct packed {
        logic neg_s;
        logic neg_t;
        logic center;
    } t_sb_tex;

endpackage

`default_nettype wire

[hw/rtl/sphere_map_texcoord_gen.sv]
`default_nettype none

// Sphere-map texture coordinate generator.
// Slave stream: one beat per vertex, tdata holds position (Q8.15) and unit
// normal (Q1.14). Master stream: one beat per vertex, tdata holds s and t
// (Q0.16), tuser flags a vertex forced to the map center.
// The camera position is to be written on the configuration channel while
// the block is idle, which the block does not enforce; it is ready out of
// reset and ignores indexes past camera_z. Throughput: one vertex per cycle
// unless the receiver stalls. Stages: two 25-stage square root units, two
// 17-stage dividers, ten arithmetic stages and the output register.
// The whole pipeline advances as one: when the receiver stalls with a beat
// waiting, every stage holds and o_s_tready drops; nothing is lost.
// Reset clears the camera registers and all stage valid bits and holds both
// ready outputs low; the first beat may be taken in the cycle after reset
// is released.
module sphere_map_texcoord_gen
    import smt_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // input vertex stream
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // pos_x[23:0], pos_y[47:24], pos_z[71:48],
    // norm_x[87:72], norm_y[103:88], norm_z[119:104]
    input  wire logic [119:0] i_s_tdata,
    // output texcoord stream
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // tex_s[15:0], tex_t[31:16]
    output logic [31:0]       o_m_tdata,
    // center_used[0]
    output logic [0:0]        o_m_tuser,
    // configuration write channel
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [23:0]  i_cfg_data
);

    logic en;

    // camera registers
    logic signed [23:0] r_cam_x, r_cam_y, r_cam_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x <= '0;
            r_cam_y <= '0;
            r_cam_z <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CAMERA_X: r_cam_x <= i_cfg_data;
                CFG_CAMERA_Y: r_cam_y <= i_cfg_data;
                CFG_CAMERA_Z: r_cam_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = i_rst_n;

    // global advance: the output register is empty or being drained
    logic r_out_vld;
    assign en         = !r_out_vld || i_m_tready;
    assign o_s_tready = en && i_rst_n;

    // ------------------------------------------------------------------
    // S1: view vector
    logic               r1_vld;
    logic signed [24:0] r1_v [3];
    logic signed [15:0] r1_n [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_vld <= 1'b0;
        else if (en)  r1_vld <= i_s_tvalid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_v[0] <= 25'($signed(i_s_tdata[23:0])) - 25'(r_cam_x);
            r1_v[1] <= 25'($signed(i_s_tdata[47:24])) - 25'(r_cam_y);
            r1_v[2] <= 25'($signed(i_s_tdata[71:48])) - 25'(r_cam_z);
            r1_n[0] <= $signed(i_s_tdata[87:72]);
            r1_n[1] <= $signed(i_s_tdata[103:88]);
            r1_n[2] <= $signed(i_s_tdata[119:104]);
        end
    end

    // S2: squares
    logic               r2_vld;
    logic [48:0]        r2_sq [3];
    logic signed [24:0] r2_v [3];
    logic signed [15:0] r2_n [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_vld <= 1'b0;
        else if (en)  r2_vld <= r1_vld;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r2_sq[i] <= 49'(r1_v[i] * r1_v[i]);
                r2_v[i]  <= r1_v[i];
                r2_n[i]  <= r1_n[i];
            end
        end
    end

    // S3: squared length
    logic               r3_vld;
    logic [ISQ_W-1:0]   r3_len2;
    logic signed [24:0] r3_v [3];
    logic signed [15:0] r3_n [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_vld <= 1'b0;
        else if (en)  r3_vld <= r2_vld;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_len2 <= ISQ_W'(r2_sq[0]) + ISQ_W'(r2_sq[1]) + ISQ_W'(r2_sq[2]);
            r3_v    <= r2_v;
            r3_n    <= r2_n;
        end
    end

    // ------------------------------------------------------------------
    // length = floor(sqrt(len2)), side data delayed alongside
    logic [ISQ_N-1:0] len_root;
    t_sb_len          sb1_in;
    t_sb_len          r_d1 [ISQ_N];
    logic [ISQ_N-1:0] r_d1_vld;

    smt_isqrt u_len_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r3_len2),
        .o_root (len_root)
    );

    always_comb begin
        sb1_in.vx   = r3_v[0];
        sb1_in.vy   = r3_v[1];
        sb1_in.vz   = r3_v[2];
        sb1_in.nx   = r3_n[0];
        sb1_in.ny   = r3_n[1];
        sb1_in.nz   = r3_n[2];
        sb1_in.zero = (r3_len2 == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d1_vld <= '0;
        else if (en)  r_d1_vld <= {r_d1_vld[ISQ_N-2:0], r3_vld};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d1[0] <= sb1_in;
            for (int k = 1; k < ISQ_N; k++) r_d1[k] <= r_d1[k-1];
        end
    end

    // ------------------------------------------------------------------
    // normalize: |v_i| * 65536 / length on three dividers
    t_sb_len           sb1_out;
    logic signed [24:0] vv [3];
    logic [24:0]       vmag [3];
    logic [DIV_N-1:0]  nq [3];
    logic              nq_ovf [3];
    t_sb_norm          sb2_in;
    t_sb_norm          r_d2 [DIV_N];
    logic [DIV_N-1:0]  r_d2_vld;

    assign sb1_out = r_d1[ISQ_N-1];
    assign vv[0]   = sb1_out.vx;
    assign vv[1]   = sb1_out.vy;
    assign vv[2]   = sb1_out.vz;

    for (genvar i = 0; i < 3; i++) begin : g_norm
        assign vmag[i] = vv[i][24] ? 25'(-vv[i]) : 25'(vv[i]);

        smt_div u_norm_div (
            .i_clk      (i_clk),
            .i_en       (en),
            .i_dividend ({vmag[i], 16'b0}),
            .i_divisor  (len_root),
            .o_quot     (nq[i]),
            .o_ovf      (nq_ovf[i])
        );
    end

    always_comb begin
        sb2_in.neg  = {vv[2][24], vv[1][24], vv[0][24]};
        sb2_in.nx   = sb1_out.nx;
        sb2_in.ny   = sb1_out.ny;
        sb2_in.nz   = sb1_out.nz;
        sb2_in.zero = sb1_out.zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d2_vld <= '0;
        else if (en)  r_d2_vld <= {r_d2_vld[DIV_N-2:0], r_d1_vld[ISQ_N-1]};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d2[0] <= sb2_in;
            for (int k = 1; k < DIV_N; k++) r_d2[k] <= r_d2[k-1];
        end
    end

    // ------------------------------------------------------------------
    // SA: signed unit vector u (Q.16)
    t_sb_norm           sb2_out;
    logic signed [15:0] nn [3];
    logic               ra_vld;
    logic signed [17:0] ra_u [3];
    logic signed [15:0] ra_n [3];
    logic               ra_zero;

    assign sb2_out = r_d2[DIV_N-1];
    assign nn[0]   = sb2_out.nx;
    assign nn[1]   = sb2_out.ny;
    assign nn[2]   = sb2_out.nz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) ra_vld <= 1'b0;
        else if (en)  ra_vld <= r_d2_vld[DIV_N-1];
    end

    // quotient never exceeds 65536 since |v_i| <= length; overflow unused
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                ra_u[i] <= sb2_out.neg[i] ? -$signed({1'b0, nq[i]})
                                          :  $signed({1'b0, nq[i]});
                ra_n[i] <= nn[i];
            end
            ra_zero <= sb2_out.zero | nq_ovf[0] & 1'b0;
        end
    end

    // SB: products n_i * u_i
    logic               rb_vld;
    logic signed [33:0] rb_p [3];
    logic signed [17:0] rb_u [3];
    logic signed [15:0] rb_n [3];
    logic               rb_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rb_vld <= 1'b0;
        else if (en)  rb_vld <= ra_vld;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) rb_p[i] <= ra_n[i] * ra_u[i];
            rb_u    <= ra_u;
            rb_n    <= ra_n;
            rb_zero <= ra_zero;
        end
    end

    // SC: dot product, Q.30
    logic               rc_vld;
    logic signed [35:0] rc_d;
    logic signed [17:0] rc_u [3];
    logic signed [15:0] rc_n [3];
    logic               rc_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rc_vld <= 1'b0;
        else if (en)  rc_vld <= rb_vld;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rc_d    <= 36'(rb_p[0]) + 36'(rb_p[1]) + 36'(rb_p[2]);
            rc_u    <= rb_u;
            rc_n    <= rb_n;
            rc_zero <= rb_zero;
        end
    end

    // SD: n_i * d split into high and low partial products
    logic signed [17:0] d_hi;
    logic signed [18:0] d_lo;
    logic               rd_vld;
    logic signed [33:0] rd_mh [3];
    logic signed [34:0] rd_ml [3];
    logic signed [17:0] rd_u [3];
    logic               rd_zero;

    assign d_hi = rc_d[35:18];
    assign d_lo = $signed({1'b0, rc_d[17:0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rd_vld <= 1'b0;
        else if (en)  rd_vld <= rc_vld;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                rd_mh[i] <= rc_n[i] * d_hi;
                rd_ml[i] <= rc_n[i] * d_lo;
            end
            rd_u    <= rc_u;
            rd_zero <= rc_zero;
        end
    end

    // SE: combine partial products into n_i * d
    logic               re_vld;
    logic signed [51:0] re_p [3];
    logic signed [17:0] re_u [3];
    logic               re_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) re_vld <= 1'b0;
        else if (en)  re_vld <= rd_vld;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                re_p[i] <= (52'(rd_mh[i]) <<< 18) + 52'(rd_ml[i]);
            end
            re_u    <= rd_u;
            re_zero <= rd_zero;
        end
    end

    // SF: reflection r_i = u_i + floor(-2 n_i d / 2^28)
    logic               rf_vld;
    logic signed [24:0] rf_r [3];
    logic               rf_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rf_vld <= 1'b0;
        else if (en)  rf_vld <= re_vld;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                rf_r[i] <= 25'(re_u[i]) + 25'((-re_p[i]) >>> 27);
            end
            rf_zero <= re_zero;
        end
    end

    // SG: axis swap, center test and radicand (2z'+2) * 2^32 in Q.16 terms
    logic signed [26:0] mm;
    logic               rg_vld;
    logic [ISQ_W-1:0]   rg_rad;
    t_sb_root           rg_sb;

    assign mm = 27'sd131072 - (27'(rf_r[1]) <<< 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rg_vld <= 1'b0;
        else if (en)  rg_vld <= rf_vld;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rg_rad       <= ISQ_W'({mm[25:0], 16'b0});
            rg_sb.xs     <= rf_r[0];
            rg_sb.ys     <= rf_r[2];
            rg_sb.center <= rf_zero || (rf_r[1] >= 25'sd65536);
        end
    end

    // ------------------------------------------------------------------
    // second square root, side data delayed alongside
    logic [ISQ_N-1:0] s_root;
    t_sb_root         r_d3 [ISQ_N];
    logic [ISQ_N-1:0] r_d3_vld;

    smt_isqrt u_map_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (rg_rad),
        .o_root (s_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d3_vld <= '0;
        else if (en)  r_d3_vld <= {r_d3_vld[ISQ_N-2:0], rg_vld};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d3[0] <= rg_sb;
            for (int k = 1; k < ISQ_N; k++) r_d3[k] <= r_d3[k-1];
        end
    end

    // ------------------------------------------------------------------
    // final divides: |x'| * 32768 / S and |y'| * 32768 / S
    t_sb_root         sb3_out;
    logic [24:0]      xmag, ymag;
    logic [DIV_N-1:0] qs, qt;
    logic             qs_ovf, qt_ovf;
    t_sb_tex          sb4_in;
    t_sb_tex          r_d4 [DIV_N];
    logic [DIV_N-1:0] r_d4_vld;

    assign sb3_out = r_d3[ISQ_N-1];
    assign xmag    = sb3_out.xs[24] ? 25'(-sb3_out.xs) : 25'(sb3_out.xs);
    assign ymag    = sb3_out.ys[24] ? 25'(-sb3_out.ys) : 25'(sb3_out.ys);

    smt_div u_s_div (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend ({1'b0, xmag, 15'b0}),
        .i_divisor  (s_root),
        .o_quot     (qs),
        .o_ovf      (qs_ovf)
    );

    smt_div u_t_div (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend ({1'b0, ymag, 15'b0}),
        .i_divisor  (s_root),
        .o_quot     (qt),
        .o_ovf      (qt_ovf)
    );

    always_comb begin
        sb4_in.neg_s  = sb3_out.xs[24];
        sb4_in.neg_t  = sb3_out.ys[24];
        sb4_in.center = sb3_out.center;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d4_vld <= '0;
        else if (en)  r_d4_vld <= {r_d4_vld[DIV_N-2:0], r_d3_vld[ISQ_N-1]};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d4[0] <= sb4_in;
            for (int k = 1; k < DIV_N; k++) r_d4[k] <= r_d4[k-1];
        end
    end

    // ------------------------------------------------------------------
    // output register: offset by one half and saturate
    t_sb_tex     sb4_out;
    logic [15:0] n_tex_s, n_tex_t;
    logic [15:0] r_tex_s, r_tex_t;
    logic        r_center;

    assign sb4_out = r_d4[DIV_N-1];

    always_comb begin
        if (sb4_out.center) begin
            n_tex_s = 16'h8000;
        end else if (sb4_out.neg_s) begin
            n_tex_s = (qs_ovf || qs >= 17'd32768) ? 16'h0000
                                                  : 16'(17'd32768 - qs);
        end else begin
            n_tex_s = (qs_ovf || qs >= 17'd32767) ? 16'hFFFF
                                                  : 16'(17'd32768 + qs);
        end
        if (sb4_out.center) begin
            n_tex_t = 16'h8000;
        end else if (sb4_out.neg_t) begin
            n_tex_t = (qt_ovf || qt >= 17'd32768) ? 16'h0000
                                                  : 16'(17'd32768 - qt);
        end else begin
            n_tex_t = (qt_ovf || qt >= 17'd32767) ? 16'hFFFF
                                                  : 16'(17'd32768 + qt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_vld <= 1'b0;
        else if (en)  r_out_vld <= r_d4_vld[DIV_N-1];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tex_s  <= n_tex_s;
            r_tex_t  <= n_tex_t;
            r_center <= sb4_out.center;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {r_tex_t, r_tex_s};
    assign o_m_tuser  = r_center;

endmodule

`default_nettype wire

[hw/rtl/smt_isqrt.sv]
`default_nettype none

// Pipelined integer square root, floor(sqrt(i_rad)), one root bit per stage
module smt_isqrt
    import smt_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [ISQ_W-1:0] i_rad,
    output logic      [ISQ_N-1:0] o_root
);

    logic [ISQ_N+1:0] r_rem  [ISQ_N];
    logic [ISQ_N-1:0] r_root [ISQ_N];
    logic [ISQ_W-1:0] r_rad  [ISQ_N-1];

    for (genvar k = 0; k < ISQ_N; k++) begin : g_stage
        logic [ISQ_W-1:0] rad_in;
        logic [ISQ_N+1:0] rem_in;
        logic [ISQ_N-1:0] root_in;
        logic [ISQ_N+3:0] cur;
        logic [ISQ_N+3:0] trial;
        logic             ge;

        if (k == 0) begin : g_first
            assign rad_in  = i_rad;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign rad_in  = r_rad[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end

        // bring down the next bit pair and try (4*root + 1)
        assign cur   = {rem_in, rad_in[2*(ISQ_N-1-k)+1 -: 2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign ge    = (cur >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (ge) begin
                    r_rem[k]  <= (ISQ_N+2)'(cur - trial);
                    r_root[k] <= {root_in[ISQ_N-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= cur[ISQ_N+1:0];
                    r_root[k] <= {root_in[ISQ_N-2:0], 1'b0};
                end
            end
        end

        if (k < ISQ_N-1) begin : g_rad
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rad[k] <= rad_in;
                end
            end
        end
    end

    assign o_root = r_root[ISQ_N-1];

endmodule

`default_nettype wire

[hw/rtl/smt_div.sv]
`default_nettype none

// Pipelined unsigned restoring divider, one quotient bit per stage.
// o_ovf flags a quotient that does not fit in DIV_N bits.
module smt_div
    import smt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [DIV_AW-1:0] i_dividend,
    input  wire logic [DIV_DW-1:0] i_divisor,
    output logic      [DIV_N-1:0]  o_quot,
    output logic                   o_ovf
);

    logic [DIV_DW-1:0] r_rem [DIV_N-1];
    logic [DIV_AW-1:0] r_a   [DIV_N-1];
    logic [DIV_DW-1:0] r_dv  [DIV_N-1];
    logic [DIV_N-1:0]  r_q   [DIV_N];
    logic              r_ovf [DIV_N];

    for (genvar k = 0; k < DIV_N; k++) begin : g_stage
        logic [DIV_DW-1:0] rem_in;
        logic [DIV_AW-1:0] a_in;
        logic [DIV_DW-1:0] d_in;
        logic [DIV_N-1:0]  q_in;
        logic              ovf_in;
        logic [DIV_DW:0]   cur;
        logic              ge;

        if (k == 0) begin : g_first
            assign rem_in = DIV_DW'(i_dividend[DIV_AW-1:DIV_N]);
            assign a_in   = i_dividend;
            assign d_in   = i_divisor;
            assign q_in   = '0;
            // high part already at least the divisor: quotient too wide
            assign ovf_in = (DIV_DW'(i_dividend[DIV_AW-1:DIV_N]) >= i_divisor);
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign a_in   = r_a[k-1];
            assign d_in   = r_dv[k-1];
            assign q_in   = r_q[k-1];
            assign ovf_in = r_ovf[k-1];
        end

        assign cur = {rem_in, a_in[DIV_N-1-k]};
        assign ge  = (cur >= {1'b0, d_in});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k]   <= {q_in[DIV_N-2:0], ge};
                r_ovf[k] <= ovf_in;
            end
        end

        if (k < DIV_N-1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? DIV_DW'(cur - {1'b0, d_in}) : cur[DIV_DW-1:0];
                    r_a[k]   <= a_in;
                    r_dv[k]  <= d_in;
                end
            end
        end
    end

    assign o_quot = r_q[DIV_N-1];
    assign o_ovf  = r_ovf[DIV_N-1];

endmodule

`default_nettype wire
